FILE: design/hlp_pkg.sv
// Shared types, codes and helper functions of the hex page loader parser.
`default_nettype none

package hlp_pkg;

  // Command characters of the loader protocol.
  localparam logic [7:0] CH_PAGE  = 8'h70;  // 'p'
  localparam logic [7:0] CH_SEND  = 8'h73;  // 's'
  localparam logic [7:0] CH_WRITE = 8'h77;  // 'w'
  localparam logic [7:0] CH_EXIT  = 8'h78;  // 'x'
  localparam logic [7:0] CH_RESET = 8'h72;  // 'r'

  localparam logic [15:0] CRC_POLY = 16'h1021;

  typedef enum logic [3:0] {
    MODE_IDLE = 4'b0001,
    MODE_ADDR = 4'b0010,
    MODE_DATA = 4'b0100,
    MODE_CRC  = 4'b1000
  } mode_t;

  typedef enum logic [3:0] {
    EV_ACCEPTED  = 4'd0,
    EV_STORED    = 4'd1,
    EV_LAST_BYTE = 4'd2,
    EV_ADDR_DONE = 4'd3,
    EV_CRC_OK    = 4'd4,
    EV_CRC_BAD   = 4'd5,
    EV_PROGRAM   = 4'd6,
    EV_EXIT      = 4'd7,
    EV_ABORT     = 4'd8
  } event_t;

  typedef struct packed {
    mode_t       mode;
    logic [2:0]  digit_count;
    logic [7:0]  pending_byte;
    logic [31:0] address_accum;
    logic [15:0] running_crc;
    logic [15:0] parsed_crc;
  } state_t;

  typedef struct packed {
    event_t      event_res;
    logic [7:0]  byte_index;
    logic [7:0]  byte_value;
    logic [31:0] page_address;
    logic [15:0] computed_crc;
    logic [15:0] received_crc;
    logic        last;
  } result_t;

  // Up to two results per character: the mode's own result, then an abort.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } decode_out_t;

  // Characters that are not hex digits count as zero.
  function automatic logic [3:0] hex_nibble(input logic [7:0] ch);
    logic [3:0] v;
    v = 4'd0;
    if (ch >= 8'h30 && ch <= 8'h39) v = 4'(ch - 8'h30);
    else if (ch >= 8'h41 && ch <= 8'h46) v = 4'(ch - 8'h37);
    else if (ch >= 8'h61 && ch <= 8'h66) v = 4'(ch - 8'h57);
    return v;
  endfunction

  // CRC-16 XMODEM, one byte, most significant bit first.
  function automatic logic [15:0] crc_update(input logic [15:0] crc,
                                             input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
      else c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: design/hlp_char_if.sv
// Valid/ready channel that carries received characters.
`default_nettype none

interface hlp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_char;

  modport source (output valid, output rx_char, input ready);
  modport sink (input valid, input rx_char, output ready);
endinterface

`default_nettype wire

FILE: design/hlp_event_if.sv
// Valid/ready channel that carries parser result words.
`default_nettype none

interface hlp_event_if;
  logic        valid;
  logic        ready;
  logic [3:0]  event_res;
  logic [7:0]  byte_index;
  logic [7:0]  byte_value;
  logic [31:0] page_address;
  logic [15:0] computed_crc;
  logic [15:0] received_crc;
  logic        last;

  modport source (output valid, output event_res, output byte_index, output byte_value,
                  output page_address, output computed_crc, output received_crc,
                  output last, input ready);
  modport sink (input valid, input event_res, input byte_index, input byte_value,
                input page_address, input computed_crc, input received_crc,
                input last, output ready);
endinterface

`default_nettype wire

FILE: design/hlp_decode.sv
// Next-state and result logic for one received character.
`default_nettype none

module hlp_decode #(
  parameter int PAGE_BYTES = 256
) (
  input  wire hlp_pkg::state_t              cur,
  input  wire logic [$clog2(PAGE_BYTES)-1:0] fill_cur,
  input  wire logic [7:0]                    rx_char,
  output hlp_pkg::state_t                   nxt,
  output logic [$clog2(PAGE_BYTES)-1:0]      fill_next,
  output hlp_pkg::decode_out_t               res
);

  localparam int FILL_W = $clog2(PAGE_BYTES);
  localparam logic [FILL_W-1:0] LAST_IDX = FILL_W'(PAGE_BYTES - 1);

  always_comb begin
    hlp_pkg::state_t  st;
    logic [FILL_W-1:0] fi;
    logic [3:0]        nib;
    logic [7:0]        data_byte;
    logic              prim_valid;
    hlp_pkg::result_t  prim;
    hlp_pkg::result_t  abrt;

    st         = cur;
    fi         = fill_cur;
    nib        = hlp_pkg::hex_nibble(rx_char);
    data_byte  = 8'd0;
    prim_valid = 1'b0;
    prim       = '0;
    abrt       = '0;

    case (cur.mode)
      hlp_pkg::MODE_IDLE: begin
        if (rx_char == hlp_pkg::CH_PAGE) begin
          st.address_accum = 32'd0;
          st.mode          = hlp_pkg::MODE_ADDR;
          prim_valid       = 1'b1;
          prim.event_res   = hlp_pkg::EV_ACCEPTED;
        end else if (rx_char == hlp_pkg::CH_SEND) begin
          st.mode        = hlp_pkg::MODE_DATA;
          prim_valid     = 1'b1;
          prim.event_res = hlp_pkg::EV_ACCEPTED;
        end else if (rx_char == hlp_pkg::CH_WRITE) begin
          prim_valid     = 1'b1;
          prim.event_res = hlp_pkg::EV_PROGRAM;
        end else if (rx_char == hlp_pkg::CH_EXIT) begin
          prim_valid     = 1'b1;
          prim.event_res = hlp_pkg::EV_EXIT;
        end
        prim.byte_index   = 8'd0;
        prim.byte_value   = rx_char;
        prim.page_address = st.address_accum;
        prim.computed_crc = st.running_crc;
        prim.received_crc = st.parsed_crc;
        // The program command reports the address before it is cleared.
        if (rx_char == hlp_pkg::CH_WRITE) begin
          st.address_accum = 32'd0;
          fi               = '0;
        end
      end
      hlp_pkg::MODE_ADDR: begin
        st.running_crc = hlp_pkg::crc_update(cur.running_crc, rx_char);
        if (cur.digit_count != 3'd7) begin
          st.address_accum = cur.address_accum |
                             (32'(nib) << {(3'd7 - cur.digit_count), 2'b00});
          st.digit_count   = cur.digit_count + 3'd1;
        end else begin
          st.digit_count   = 3'd0;
          st.pending_byte  = 8'd0;
          st.address_accum = cur.address_accum | 32'(nib);
          st.mode          = hlp_pkg::MODE_CRC;
          prim_valid       = 1'b1;
          prim.event_res   = hlp_pkg::EV_ADDR_DONE;
        end
        prim.byte_index   = 8'd0;
        prim.byte_value   = rx_char;
        prim.page_address = st.address_accum;
        prim.computed_crc = st.running_crc;
        prim.received_crc = st.parsed_crc;
      end
      hlp_pkg::MODE_DATA: begin
        st.running_crc = hlp_pkg::crc_update(cur.running_crc, rx_char);
        if (cur.digit_count == 3'd0) begin
          st.pending_byte = {nib, 4'h0};
          st.digit_count  = 3'd1;
        end else begin
          data_byte       = cur.pending_byte | {4'h0, nib};
          st.digit_count  = 3'd0;
          st.pending_byte = 8'd0;
          prim_valid      = 1'b1;
          prim.byte_index = 8'(fill_cur);
          if (fill_cur < LAST_IDX) begin
            prim.event_res = hlp_pkg::EV_STORED;
            fi             = fill_cur + FILL_W'(1);
          end else begin
            // A full page keeps its index at the last position until 'w'.
            fi              = LAST_IDX;
            prim.byte_index = 8'(LAST_IDX);
            prim.event_res  = hlp_pkg::EV_LAST_BYTE;
            st.mode         = hlp_pkg::MODE_CRC;
          end
        end
        prim.byte_value   = data_byte;
        prim.page_address = st.address_accum;
        prim.computed_crc = st.running_crc;
        prim.received_crc = st.parsed_crc;
      end
      hlp_pkg::MODE_CRC: begin
        if (cur.digit_count < 3'd3) begin
          st.parsed_crc  = cur.parsed_crc |
                           (16'(nib) << {(2'd3 - cur.digit_count[1:0]), 2'b00});
          st.digit_count = cur.digit_count + 3'd1;
        end else begin
          st.parsed_crc  = cur.parsed_crc | 16'(nib);
          prim_valid     = 1'b1;
          prim.event_res = (st.parsed_crc == cur.running_crc) ?
                           hlp_pkg::EV_CRC_OK : hlp_pkg::EV_CRC_BAD;
        end
        prim.byte_index   = 8'd0;
        prim.byte_value   = rx_char;
        prim.page_address = st.address_accum;
        prim.computed_crc = st.running_crc;
        prim.received_crc = st.parsed_crc;
        if (prim_valid) begin
          st.digit_count  = 3'd0;
          st.pending_byte = 8'd0;
          st.running_crc  = 16'd0;
          st.parsed_crc   = 16'd0;
          st.mode         = hlp_pkg::MODE_IDLE;
        end
      end
      default: begin
        st.mode = hlp_pkg::MODE_IDLE;
      end
    endcase

    // Abort follows whatever the current mode did with the character.
    if (rx_char == hlp_pkg::CH_RESET) begin
      st.mode         = hlp_pkg::MODE_IDLE;
      st.digit_count  = 3'd0;
      st.pending_byte = 8'd0;
    end
    abrt.event_res    = hlp_pkg::EV_ABORT;
    abrt.byte_index   = 8'd0;
    abrt.byte_value   = rx_char;
    abrt.page_address = st.address_accum;
    abrt.computed_crc = st.running_crc;
    abrt.received_crc = st.parsed_crc;
    abrt.last         = 1'b1;

    res = '0;
    if (prim_valid && rx_char == hlp_pkg::CH_RESET) begin
      res.count  = 2'd2;
      prim.last  = 1'b0;
      res.first  = prim;
      res.second = abrt;
    end else if (prim_valid) begin
      res.count  = 2'd1;
      prim.last  = 1'b1;
      res.first  = prim;
    end else if (rx_char == hlp_pkg::CH_RESET) begin
      res.count  = 2'd1;
      res.first  = abrt;
    end

    nxt       = st;
    fill_next = fi;
  end

endmodule

`default_nettype wire

FILE: design/hlp_result_fifo.sv
// Four-word result queue that takes up to two words per cycle and gives one when the receiver is ready.
`default_nettype none

module hlp_result_fifo (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire hlp_pkg::decode_out_t  push_data,
  input  wire logic                  pop_ready,
  output logic                       head_valid,
  output hlp_pkg::result_t           head,
  output logic                       room
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  hlp_pkg::result_t   entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic [1:0]         push_n;
  logic               pop;

  assign push_n     = push ? push_data.count : 2'd0;
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign pop        = head_valid && pop_ready;
  // Room for two words lets any character be accepted together with all of its words.
  assign room       = (count <= CNT_W'(DEPTH - 2));
  assign count_next = count + CNT_W'(push_n) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_n);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) entries[wr_ptr] <= push_data.first;
    if (push_n == 2'd2) entries[wr_ptr + PTR_W'(1)] <= push_data.second;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("result queue overfilled");

  a_stall_keeps_words: assert property (@(posedge clk) disable iff (rst)
    head_valid && !pop_ready |=> count >= $past(count))
    else $error("result word lost while receiver stalled");

  a_push_only_with_room: assert property (@(posedge clk) disable iff (rst)
    push_n != 2'd0 |-> count <= CNT_W'(DEPTH - 2))
    else $error("words pushed without room");

endmodule

`default_nettype wire

FILE: design/hex_page_loader_parser.sv
// Hex page loader parser: characters in on chars, event words out on events.
// Each accepted character (one word on chars) is decoded against the parser
// state in the same cycle, and the zero, one or two event words it causes
// are written into a four-word result queue. Event words are registered in
// the queue and shown on events behind any words already waiting there.
// A character is taken whenever the queue has room for two words, so one
// character per cycle is sustained while events drains one word per cycle;
// characters that cause two words (a final digit that is also 'r') fill the
// queue faster than events drains it. The character decode and the CRC-16
// byte update are the logic between state registers and the queue.
// When the receiver of events stalls, words wait in the queue and chars
// drops ready once fewer than two free slots remain; nothing is lost.
// Reset (rst, synchronous) returns the parser to idle with the address,
// fill index and both CRC values at zero and empties the queue.
// The word with last set is the final event of its character.
`default_nettype none

module hex_page_loader_parser #(
  parameter int PAGE_BYTES = 256
) (
  input wire logic   clk,
  input wire logic   rst,
  hlp_char_if.sink   chars,
  hlp_event_if.source events
);

  localparam int FILL_W = $clog2(PAGE_BYTES);

  hlp_pkg::state_t      state;
  hlp_pkg::state_t      state_next;
  logic [FILL_W-1:0]    fill_index;
  logic [FILL_W-1:0]    fill_index_next;
  hlp_pkg::decode_out_t dec;
  hlp_pkg::result_t     head;
  logic                 room;
  logic                 accept;

  assign chars.ready = room;
  assign accept      = chars.valid && room;

  hlp_decode #(.PAGE_BYTES(PAGE_BYTES)) u_decode (
    .cur       (state),
    .fill_cur  (fill_index),
    .rx_char   (chars.rx_char),
    .nxt       (state_next),
    .fill_next (fill_index_next),
    .res       (dec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode          <= hlp_pkg::MODE_IDLE;
      state.digit_count   <= 3'd0;
      state.pending_byte  <= 8'd0;
      state.address_accum <= 32'd0;
      state.running_crc   <= 16'd0;
      state.parsed_crc    <= 16'd0;
      fill_index          <= '0;
    end else if (accept) begin
      state      <= state_next;
      fill_index <= fill_index_next;
    end
  end

  hlp_result_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_data  (dec),
    .pop_ready  (events.ready),
    .head_valid (events.valid),
    .head       (head),
    .room       (room)
  );

  assign events.event_res    = head.event_res;
  assign events.byte_index   = head.byte_index;
  assign events.byte_value   = head.byte_value;
  assign events.page_address = head.page_address;
  assign events.computed_crc = head.computed_crc;
  assign events.received_crc = head.received_crc;
  assign events.last         = head.last;

  a_abort_to_idle: assert property (@(posedge clk) disable iff (rst)
    accept && chars.rx_char == hlp_pkg::CH_RESET |=> state.mode == hlp_pkg::MODE_IDLE)
    else $error("abort character did not return parser to idle");

  a_idle_no_digits: assert property (@(posedge clk) disable iff (rst)
    state.mode == hlp_pkg::MODE_IDLE |-> state.digit_count == 3'd0)
    else $error("digit count left over in idle");

  a_hold_without_accept: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(state) && $stable(fill_index))
    else $error("parser state changed without an accepted character");

endmodule

`default_nettype wire

FILE: tb/sv/tb_hex_page_loader_parser.sv
// Self-checking testbench of the hex page loader parser with a built-in scoreboard.
module tb_hex_page_loader_parser;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAGE_BYTES = 256;
  localparam int ITEMS = 2000;

  class loader_scoreboard;
    hlp_pkg::mode_t   mode;
    logic [2:0]       digits;
    logic [7:0]       pend;
    logic [31:0]      addr;
    int               fill;
    logic [15:0]      crc;
    logic [15:0]      rcv_crc;
    hlp_pkg::result_t awaited[$];
    int               errors;

    function new();
      mode = hlp_pkg::MODE_IDLE;
      digits = '0;
      pend = '0;
      addr = '0;
      fill = 0;
      crc = '0;
      rcv_crc = '0;
      errors = 0;
    endfunction

    function logic [3:0] digit_value(input logic [7:0] c);
      if (c >= "0" && c <= "9") return 4'(c - "0");
      if (c >= "A" && c <= "F") return 4'(c - "A" + 10);
      if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
      return 4'h0;
    endfunction

    function logic [15:0] xmodem_byte(input logic [15:0] acc, input logic [7:0] b);
      logic [15:0] r;
      r = acc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) r = r[15] ? ({r[14:0], 1'b0} ^ 16'h1021) : {r[14:0], 1'b0};
      return r;
    endfunction

    function void add_word(input hlp_pkg::event_t ev, input logic [7:0] idx,
                           input logic [7:0] val);
      hlp_pkg::result_t w;
      w.event_res = ev;
      w.byte_index = idx;
      w.byte_value = val;
      w.page_address = addr;
      w.computed_crc = crc;
      w.received_crc = rcv_crc;
      w.last = 1'b0;
      awaited.push_back(w);
    endfunction

    function void note_char(input logic [7:0] c);
      logic [3:0] nib;
      logic [7:0] b;
      int         start;
      nib = digit_value(c);
      start = awaited.size();
      case (mode)
        hlp_pkg::MODE_IDLE: begin
          if (c == hlp_pkg::CH_PAGE) begin
            addr = '0;
            mode = hlp_pkg::MODE_ADDR;
            add_word(hlp_pkg::EV_ACCEPTED, 8'h00, c);
          end else if (c == hlp_pkg::CH_SEND) begin
            mode = hlp_pkg::MODE_DATA;
            add_word(hlp_pkg::EV_ACCEPTED, 8'h00, c);
          end else if (c == hlp_pkg::CH_WRITE) begin
            add_word(hlp_pkg::EV_PROGRAM, 8'h00, c);
            addr = '0;
            fill = 0;
          end else if (c == hlp_pkg::CH_EXIT) begin
            add_word(hlp_pkg::EV_EXIT, 8'h00, c);
          end
        end
        hlp_pkg::MODE_ADDR: begin
          crc = xmodem_byte(crc, c);
          if (digits < 3'd7) begin
            addr |= {28'h0, nib} << (4 * (7 - int'(digits)));
            digits++;
          end else begin
            digits = '0;
            pend = '0;
            addr |= {28'h0, nib};
            mode = hlp_pkg::MODE_CRC;
            add_word(hlp_pkg::EV_ADDR_DONE, 8'h00, c);
          end
        end
        hlp_pkg::MODE_DATA: begin
          crc = xmodem_byte(crc, c);
          if (digits == 3'd0) begin
            pend = {nib, 4'h0};
            digits = 3'd1;
          end else begin
            b = pend | {4'h0, nib};
            digits = '0;
            pend = '0;
            if (fill < PAGE_BYTES - 1) begin
              add_word(hlp_pkg::EV_STORED, 8'(fill), b);
              fill++;
            end else begin
              fill = PAGE_BYTES - 1;
              add_word(hlp_pkg::EV_LAST_BYTE, 8'(fill), b);
              mode = hlp_pkg::MODE_CRC;
            end
          end
        end
        hlp_pkg::MODE_CRC: begin
          if (digits < 3'd3) begin
            rcv_crc |= {12'h0, nib} << (4 * (3 - int'(digits)));
            digits++;
          end else begin
            rcv_crc |= {12'h0, nib};
            if (rcv_crc == crc) add_word(hlp_pkg::EV_CRC_OK, 8'h00, c);
            else add_word(hlp_pkg::EV_CRC_BAD, 8'h00, c);
            digits = '0;
            pend = '0;
            crc = '0;
            rcv_crc = '0;
            mode = hlp_pkg::MODE_IDLE;
          end
        end
        default: ;
      endcase
      // An abort comes after whatever the current mode made of the character.
      if (c == hlp_pkg::CH_RESET) begin
        mode = hlp_pkg::MODE_IDLE;
        digits = '0;
        pend = '0;
        add_word(hlp_pkg::EV_ABORT, 8'h00, c);
      end
      if (awaited.size() > start) awaited[awaited.size() - 1].last = 1'b1;
    endfunction

    function void check_word(input hlp_pkg::result_t got);
      hlp_pkg::result_t exp;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected event word ev=%0d idx=%0d val=%h", $time,
                 got.event_res, got.byte_index, got.byte_value);
        errors++;
      end else begin
        exp = awaited.pop_front();
        if (exp !== got) begin
          $display("%0t: expected ev=%0d idx=%0d val=%h addr=%h crc=%h rcv=%h last=%b",
                   $time, exp.event_res, exp.byte_index, exp.byte_value,
                   exp.page_address, exp.computed_crc, exp.received_crc, exp.last);
          $display("%0t:   actual ev=%0d idx=%0d val=%h addr=%h crc=%h rcv=%h last=%b",
                   $time, got.event_res, got.byte_index, got.byte_value,
                   got.page_address, got.computed_crc, got.received_crc, got.last);
          errors++;
        end
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  hlp_char_if  chars();
  hlp_event_if events();

  hex_page_loader_parser #(
    .PAGE_BYTES(PAGE_BYTES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .chars(chars),
    .events(events)
  );

  loader_scoreboard sb;
  bit               no_gaps;
  int               sent_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("FAILURE");
    $finish;
  end

  function automatic int gap_draw();
    return no_gaps ? 0 : $urandom_range(0, 13);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'("0" + v);
    return 8'(($urandom_range(0, 1) ? "A" : "a") + v - 10);
  endfunction

  task automatic put_char(input logic [7:0] c);
    int gap;
    gap = gap_draw();
    if (gap > 0) begin
      chars.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    chars.valid <= 1'b1;
    chars.rx_char <= c;
    do @(posedge clk); while (!chars.ready);
    sb.note_char(c);
    sent_count++;
  endtask

  task automatic drain_results();
    do @(posedge clk); while (sb.pending() > 0);
  endtask

  // Command, digits until address or data mode ends, then four CRC digits or an abort 'r'.
  task automatic send_frame(input logic [7:0] cmd);
    int          abort_at;
    int          k;
    logic [15:0] sent_crc;
    abort_at = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 40) : -1;
    k = 0;
    put_char(cmd);
    while ((sb.mode == hlp_pkg::MODE_ADDR || sb.mode == hlp_pkg::MODE_DATA) &&
           k != abort_at && sent_count < ITEMS) begin
      if ($urandom_range(0, 24) == 0) put_char(8'($urandom_range(0, 255)));
      else put_char(hex_char(4'($urandom_range(0, 15))));
      k++;
    end
    if (k == abort_at) begin
      put_char(hlp_pkg::CH_RESET);
    end else begin
      sent_crc = sb.crc ^ (($urandom_range(0, 7) == 0) ? 16'($urandom_range(1, 65535)) : 16'h0);
      for (int i = 3; i >= 0 && sb.mode == hlp_pkg::MODE_CRC; i--)
        put_char(hex_char(sent_crc[4*i +: 4]));
    end
  endtask

  // Sink side: random stalls on ready, and every accepted word goes to the scoreboard.
  initial begin
    hlp_pkg::result_t got;
    int               stall;
    do @(posedge clk); while (rst);
    forever begin
      stall = gap_draw();
      if (stall > 0) begin
        events.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      events.ready <= 1'b1;
      do @(posedge clk); while (!events.valid);
      got.event_res = hlp_pkg::event_t'(events.event_res);
      got.byte_index = events.byte_index;
      got.byte_value = events.byte_value;
      got.page_address = events.page_address;
      got.computed_crc = events.computed_crc;
      got.received_crc = events.received_crc;
      got.last = events.last;
      sb.check_word(got);
    end
  end

  initial begin
    logic [7:0] opening[];
    int         pick;
    opening = '{hlp_pkg::CH_EXIT, 8'h00, 8'hFF, hlp_pkg::CH_RESET,
                hlp_pkg::CH_PAGE, "F", "f", "0", "9", "A", "a", "G", "z",
                "1", "2", "3", hlp_pkg::CH_RESET,
                hlp_pkg::CH_SEND, "F", "F", "0", hlp_pkg::CH_RESET,
                hlp_pkg::CH_WRITE, hlp_pkg::CH_PAGE, hlp_pkg::CH_RESET};
    sb = new();
    no_gaps = 1'b0;
    sent_count = 0;
    rst = 1'b1;
    chars.valid = 1'b0;
    chars.rx_char = 8'h00;
    events.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (opening[i]) put_char(opening[i]);

    // Hold off until the directed part has fully drained.
    chars.valid <= 1'b0;
    drain_results();

    while (sent_count < ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) send_frame(hlp_pkg::CH_PAGE);
      else if (pick < 62) send_frame(hlp_pkg::CH_SEND);
      else if (pick < 72) put_char(hlp_pkg::CH_WRITE);
      else if (pick < 76) put_char(hlp_pkg::CH_EXIT);
      else if (pick < 86) repeat ($urandom_range(1, 4)) put_char(8'($urandom_range(0, 255)));
      else if (pick < 90) put_char(hlp_pkg::CH_RESET);
      else if (pick < 94) begin
        chars.valid <= 1'b0;
        drain_results();
      end else no_gaps = ~no_gaps;
    end
    chars.valid <= 1'b0;

    drain_results();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
